>>> sv/oled_framebuffer_dirty_flush_macros.svh
// Assertion helpers for the frame store block.
`ifndef OLED_FRAMEBUFFER_DIRTY_FLUSH_MACROS_SVH
`define OLED_FRAMEBUFFER_DIRTY_FLUSH_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define OFDF_ASSERT_IMP(lbl, ck, rn, a, b) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |-> (b)) \
    else $error("lbl failed");

// Next-cycle implication, disabled in reset.
`define OFDF_ASSERT_NXT(lbl, ck, rn, a, b) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |=> (b)) \
    else $error("lbl failed");

`endif

>>> sv/ofdf_pkg.sv
package ofdf_pkg;

  localparam int DEF_COLUMNS    = 128;
  localparam int DEF_PAGES      = 8;
  localparam int DEF_BEAT_BYTES = 8;
  localparam int MAX_BEATS      = 64;
  localparam int FRAME_ROWS     = 128;  // 1024 bytes held as 8-byte rows
  localparam int DIRTY_BYTES    = 128;

  localparam logic [7:0] THRESHOLD_RESET = 8'd32;
  localparam logic [1:0] OFFSET_RESET    = 2'd2;

  typedef enum logic [1:0] {
    OP_DRAW  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_FLUSH = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic {
    REG_FULL_THRESHOLD = 1'b0,
    REG_COLUMN_OFFSET  = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAW_WR,
    ST_FL_RD,
    ST_FL_PROC,
    ST_FL_FIN,
    ST_FL_LAST
  } state_t;

  typedef struct packed {
    logic sel_in;
    logic load;
    logic clear_all;
    logic draw_wr;
    logic proc;
    logic col_inc;
    logic fin;
    logic emit_last;
  } ofdf_cmd_t;

  typedef struct packed {
    logic draw_ok;
    logic is_clear;
    logic flush_ok;
    logic col_last;
  } ofdf_sts_t;

endpackage

>>> sv/oled_framebuffer_dirty_flush.sv
// Channel   Handshake               Fields
// input     start / busy            in_op in_x in_y in_on in_page
// result    out_valid (strobe)      out_page out_start_column out_data_bytes
//                                   out_byte_count out_run_start out_full_mode out_last
// config    cfg_valid / cfg_ready   cfg_index cfg_data
//
// Draw: store row and dirty byte read at accept, written back next cycle.
// Clear and ignored ops never raise busy. Flush: each column of the store is read in
// ST_FL_RD and used in ST_FL_PROC, then ST_FL_FIN and ST_FL_LAST; beats are registered.
// Reset is synchronous and clears valid bits for every store row and dirty byte
// at once, so no clearing pass is needed.
// Results are strobed for one cycle; the receiver cannot stall. cfg_ready is tied high.
module oled_framebuffer_dirty_flush #(
  parameter int COLUMNS    = ofdf_pkg::DEF_COLUMNS,
  parameter int PAGES      = ofdf_pkg::DEF_PAGES,
  parameter int BEAT_BYTES = ofdf_pkg::DEF_BEAT_BYTES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_x,
  input  logic [7:0]  in_y,
  input  logic        in_on,
  input  logic [2:0]  in_page,
  output logic        out_valid,
  output logic [2:0]  out_page,
  output logic [7:0]  out_start_column,
  output logic [63:0] out_data_bytes,
  output logic [3:0]  out_byte_count,
  output logic        out_run_start,
  output logic        out_full_mode,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);
  import ofdf_pkg::*;
  `include "oled_framebuffer_dirty_flush_macros.svh"

  ofdf_cmd_t cmd;
  ofdf_sts_t sts;

  // configuration is taken whenever offered
  assign cfg_ready = 1'b1;

  ofdf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  ofdf_dp #(
    .COLUMNS    (COLUMNS),
    .PAGES      (PAGES),
    .BEAT_BYTES (BEAT_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_op            (in_op),
    .in_x             (in_x),
    .in_y             (in_y),
    .in_on            (in_on),
    .in_page          (in_page),
    .cfg_valid        (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_page         (out_page),
    .out_start_column (out_start_column),
    .out_data_bytes   (out_data_bytes),
    .out_byte_count   (out_byte_count),
    .out_run_start    (out_run_start),
    .out_full_mode    (out_full_mode),
    .out_last         (out_last)
  );

  logic beat_cnt_ok, flush_acc;

  assign beat_cnt_ok = (out_byte_count != 4'd0) && (out_byte_count <= 4'(BEAT_BYTES));
  assign flush_acc   = start && !busy && (in_op == OP_FLUSH) && (4'(in_page) < 4'(PAGES));

  // a beat always carries between one and BEAT_BYTES bytes
  `OFDF_ASSERT_IMP(a_beat_count, clk, rst_n, out_valid, beat_cnt_ok)
  // the closing beat of a flush leaves the block idle
  `OFDF_ASSERT_IMP(a_last_idle, clk, rst_n, out_valid && out_last, !busy)
  // any earlier beat is seen while the walk is still running
  `OFDF_ASSERT_IMP(a_mid_busy, clk, rst_n, out_valid && !out_last, busy)
  // a flush of a real page accepted keeps the block busy next cycle
  `OFDF_ASSERT_NXT(a_accept_busy, clk, rst_n, flush_acc, busy)

endmodule

>>> sv/ofdf_ctrl.sv
module ofdf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  ofdf_pkg::ofdf_sts_t sts,
  output ofdf_pkg::ofdf_cmd_t cmd,
  output logic               busy
);
  import ofdf_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.sel_in = 1'b1;
        if (start) begin
          cmd.load = 1'b1;
          if (sts.draw_ok) begin
            state_nxt = ST_DRAW_WR;
          end else if (sts.is_clear) begin
            cmd.clear_all = 1'b1;
          end else if (sts.flush_ok) begin
            state_nxt = ST_FL_RD;
          end
        end
      end
      ST_DRAW_WR: begin
        cmd.draw_wr = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_FL_RD: begin
        state_nxt = ST_FL_PROC;
      end
      ST_FL_PROC: begin
        cmd.proc = 1'b1;
        if (sts.col_last) begin
          state_nxt = ST_FL_FIN;
        end else begin
          cmd.col_inc = 1'b1;
          state_nxt   = ST_FL_RD;
        end
      end
      ST_FL_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_FL_LAST;
      end
      ST_FL_LAST: begin
        cmd.emit_last = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

>>> sv/ofdf_dp.sv
module ofdf_dp #(
  parameter int COLUMNS    = ofdf_pkg::DEF_COLUMNS,
  parameter int PAGES      = ofdf_pkg::DEF_PAGES,
  parameter int BEAT_BYTES = ofdf_pkg::DEF_BEAT_BYTES
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ofdf_pkg::ofdf_cmd_t cmd,
  output ofdf_pkg::ofdf_sts_t sts,
  input  logic [1:0]          in_op,
  input  logic [7:0]          in_x,
  input  logic [7:0]          in_y,
  input  logic                in_on,
  input  logic [2:0]          in_page,
  input  logic                cfg_valid,
  input  logic                cfg_index,
  input  logic [7:0]          cfg_data,
  output logic                out_valid,
  output logic [2:0]          out_page,
  output logic [7:0]          out_start_column,
  output logic [63:0]         out_data_bytes,
  output logic [3:0]          out_byte_count,
  output logic                out_run_start,
  output logic                out_full_mode,
  output logic                out_last
);
  import ofdf_pkg::*;

  localparam int CW = $clog2(COLUMNS);
  localparam logic [3:0] BEAT_CNT = 4'(BEAT_BYTES);

  // latched command
  logic [7:0]    x_r, y_r;
  logic          on_r;
  logic [2:0]    pg_r;
  logic          full_r;
  logic [CW-1:0] col_r;

  // config and tracking state
  logic [7:0] thr_r, dpages_r, count_r;
  logic [1:0] off_r;
  logic       cleared_r;

  // memories and their valid bits
  logic [63:0] fmem [FRAME_ROWS];
  logic [7:0]  dmem [DIRTY_BYTES];
  logic [FRAME_ROWS-1:0]  fvalid_r;
  logic [DIRTY_BYTES-1:0] dvalid_r;
  logic [63:0] rdf_r;
  logic [7:0]  rdd_r;
  logic [6:0]  rrow_r, rdi_r;
  logic [2:0]  rbyte_r;

  logic [9:0] fidx;
  logic [6:0] didx;

  // beat assembly
  logic [63:0]   cur_data_r, hold_data_r;
  logic [3:0]    cur_cnt_r, hold_cnt_r;
  logic [CW-1:0] cur_col_r, hold_col_r;
  logic          cur_rs_r, hold_rs_r, hold_v_r;
  logic [6:0]    nbeats_r;

  // status
  assign sts.draw_ok  = (in_op == OP_DRAW) && (in_x < 8'(COLUMNS)) && (in_y < 8'(8 * PAGES));
  assign sts.is_clear = (in_op == OP_CLEAR);
  assign sts.flush_ok = (in_op == OP_FLUSH) && (4'(in_page) < 4'(PAGES));
  assign sts.col_last = (col_r == CW'(COLUMNS - 1));

  // read addresses: draw from the ports at accept, flush from the column walk
  always_comb begin
    if (cmd.sel_in) begin
      fidx = 10'(10'(in_y[5:3]) * 10'(COLUMNS) + 10'(in_x));
      didx = {in_y[5:3], in_x[6:3]};
    end else begin
      fidx = 10'(10'(pg_r) * 10'(COLUMNS) + 10'(col_r));
      didx = 7'({pg_r, 4'b0000} + 7'(col_r >> 3));
    end
  end

  // draw read-modify-write
  logic [63:0] frow;
  logic [7:0]  fold, fnew, dold, dmask;
  logic        fwe, dwe;
  logic [63:0] fwd;

  always_comb begin
    frow  = fvalid_r[rrow_r] ? rdf_r : 64'd0;
    fold  = frow[{rbyte_r, 3'b000} +: 8];
    fnew  = on_r ? (fold | (8'd1 << y_r[2:0])) : (fold & ~(8'd1 << y_r[2:0]));
    dold  = dvalid_r[rdi_r] ? rdd_r : 8'd0;
    dmask = 8'd1 << x_r[2:0];
    fwe   = cmd.draw_wr && (fnew != fold);
    dwe   = fwe && ((dold & dmask) == 8'd0);
    fwd   = frow;
    fwd[{rbyte_r, 3'b000} +: 8] = fnew;
  end

  always_ff @(posedge clk) begin
    if (fwe) begin
      fmem[rrow_r] <= fwd;
    end
    rdf_r <= fmem[fidx[9:3]];
  end

  always_ff @(posedge clk) begin
    if (dwe) begin
      dmem[rdi_r] <= dold | dmask;
    end
    rdd_r <= dmem[didx];
  end

  always_ff @(posedge clk) begin
    rrow_r  <= fidx[9:3];
    rbyte_r <= fidx[2:0];
    rdi_r   <= didx;
  end

  // flush walk
  logic [7:0] fbyte;
  logic       d, fin, keep, emit;

  always_comb begin
    fbyte = frow[{rbyte_r, 3'b000} +: 8];
    d     = full_r || (dpages_r[pg_r] && dold[col_r[2:0]]);
    fin   = (cmd.proc && ((d && cur_cnt_r == BEAT_CNT) || (!d && cur_cnt_r != 4'd0)))
         || (cmd.fin && cur_cnt_r != 4'd0);
    keep  = fin && (nbeats_r < 7'(MAX_BEATS));
    emit  = hold_v_r && (keep || cmd.emit_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fvalid_r  <= '0;
      dvalid_r  <= '0;
      dpages_r  <= '0;
      count_r   <= '0;
      cleared_r <= 1'b1;
      thr_r     <= THRESHOLD_RESET;
      off_r     <= OFFSET_RESET;
      hold_v_r  <= 1'b0;
      cur_cnt_r <= '0;
      nbeats_r  <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= emit;
      if (cfg_valid) begin
        unique case (reg_idx_t'(cfg_index))
          REG_FULL_THRESHOLD: thr_r <= cfg_data;
          REG_COLUMN_OFFSET:  off_r <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        hold_v_r  <= 1'b0;
        cur_cnt_r <= '0;
        nbeats_r  <= '0;
      end
      if (cmd.clear_all) begin
        fvalid_r  <= '0;
        dvalid_r  <= '0;
        dpages_r  <= '0;
        count_r   <= '0;
        cleared_r <= 1'b1;
      end
      if (fwe) begin
        fvalid_r[rrow_r] <= 1'b1;
      end
      if (dwe) begin
        dvalid_r[rdi_r]       <= 1'b1;
        dpages_r[y_r[5:3]]    <= 1'b1;
        if (count_r != 8'hFF) begin
          count_r <= count_r + 8'd1;
        end
      end
      if (keep) begin
        hold_v_r <= 1'b1;
        nbeats_r <= nbeats_r + 7'd1;
      end
      if (cmd.proc) begin
        if (d) begin
          if (cur_cnt_r == 4'd0 || cur_cnt_r == BEAT_CNT) begin
            cur_cnt_r <= 4'd1;
          end else begin
            cur_cnt_r <= cur_cnt_r + 4'd1;
          end
        end else begin
          cur_cnt_r <= '0;
        end
      end
      if (cmd.fin) begin
        cur_cnt_r <= '0;
      end
      if (cmd.emit_last) begin
        hold_v_r <= 1'b0;
        if (pg_r == 3'(PAGES - 1)) begin
          dvalid_r  <= '0;
          dpages_r  <= '0;
          count_r   <= '0;
          cleared_r <= 1'b0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r    <= in_x;
      y_r    <= in_y;
      on_r   <= in_on;
      pg_r   <= in_page;
      full_r <= cleared_r || (count_r > thr_r);
      col_r  <= '0;
    end else if (cmd.col_inc) begin
      col_r <= col_r + CW'(1);
    end
    if (cmd.proc && d) begin
      if (cur_cnt_r == 4'd0 || cur_cnt_r == BEAT_CNT) begin
        cur_data_r <= 64'(fbyte);
        cur_col_r  <= col_r;
        cur_rs_r   <= (cur_cnt_r == 4'd0);
      end else begin
        cur_data_r <= cur_data_r | (64'(fbyte) << {cur_cnt_r[2:0], 3'b000});
      end
    end
    if (keep) begin
      hold_data_r <= cur_data_r;
      hold_cnt_r  <= cur_cnt_r;
      hold_col_r  <= cur_col_r;
      hold_rs_r   <= cur_rs_r;
    end
    if (emit) begin
      out_page         <= pg_r;
      out_start_column <= 8'(hold_col_r) + 8'(off_r);
      out_data_bytes   <= hold_data_r;
      out_byte_count   <= hold_cnt_r;
      out_run_start    <= hold_rs_r;
      out_full_mode    <= full_r;
      out_last         <= cmd.emit_last;
    end
  end

endmodule
